@@ rtl/kpq_pkg.sv @@
package kpq_pkg;

  localparam int unsigned DefDepth = 64;
  localparam logic [15:0] IdStart = 16'd1000;

  // request codes
  localparam logic [2:0] REQ_PUSH    = 3'd0;
  localparam logic [2:0] REQ_POP     = 3'd1;
  localparam logic [2:0] REQ_CHANGE  = 3'd2;
  localparam logic [2:0] REQ_DELETE  = 3'd3;
  localparam logic [2:0] REQ_PROMOTE = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT,
    CELL_REMOVE,
    CELL_PROMOTE,
    CELL_SORT
  } cell_op_e;

  typedef struct packed {
    logic [15:0]        id;
    logic [30:0]        value;
    logic signed [7:0]  prio;
    logic [15:0]        market;
  } entry_t;

  typedef struct packed {
    cell_op_e    op;
    entry_t      bcast;
    logic [15:0] tid;
  } cell_cmd_t;

  // strict key compare: (priority, value) of a above b
  function automatic logic key_gt(entry_t a, entry_t b);
    if (a.prio != b.prio) begin
      return a.prio > b.prio;
    end
    return a.value > b.value;
  endfunction

endpackage

@@ rtl/kpq_cell.sv @@
module kpq_cell
  import kpq_pkg::*;
(
  input  logic      clk_i,
  input  cell_cmd_t cmd_i,
  input  logic      in_use_i,
  input  logic      dn_in_use_i,
  input  logic      sort_upper_i,
  input  entry_t    up_i,
  input  entry_t    dn_i,
  input  logic      gt_prev_i,
  input  logic      found_prev_i,
  output entry_t    entry_o,
  output logic      gt_o,
  output logic      found_o,
  output entry_t    pick_o
);

  entry_t ent_q, ent_d;
  logic   match;

  // insert point and first id match, chained through the row
  assign gt_o    = !in_use_i || key_gt(cmd_i.bcast, ent_q);
  assign match   = in_use_i && (ent_q.id == cmd_i.tid);
  assign found_o = found_prev_i || match;
  assign pick_o  = (match && !found_prev_i) ? ent_q : '0;
  assign entry_o = ent_q;

  // next content of this cell
  always_comb begin
    ent_d = ent_q;
    case (cmd_i.op)
      CELL_INSERT: begin
        if (gt_prev_i) begin
          ent_d = up_i;
        end else if (gt_o) begin
          ent_d = cmd_i.bcast;
        end
      end
      CELL_SHIFT: ent_d = dn_i;
      CELL_REMOVE: begin
        if (found_o) begin
          ent_d = dn_i;
        end
      end
      CELL_PROMOTE: begin
        if (in_use_i && ent_q.market == cmd_i.bcast.market) begin
          ent_d.prio = cmd_i.bcast.prio;
        end
      end
      CELL_SORT: begin
        if (sort_upper_i) begin
          if (dn_in_use_i && key_gt(dn_i, ent_q)) begin
            ent_d = dn_i;
          end
        end else if (in_use_i && key_gt(ent_q, up_i)) begin
          ent_d = up_i;
        end
      end
      default: ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

@@ rtl/keyed_priority_queue.sv @@
// states: push, pop EXEC, OUT (via RPT on a full or empty queue); delete, unused codes
// EXEC, RPT, OUT; change priority EXEC, CHG2, RPT, OUT (no CHG2 if the id is not found);
// promote EXEC, SORT, RPT, OUT (one odd-even sort pass per cycle; no SORT when empty)
// throughput: one request at a time, next word taken once the result is taken
// reset clears occupancy to zero and the id counter to 1000; cell contents
// are left as they are and only slots below the occupancy are ever read
module keyed_priority_queue
  import kpq_pkg::*;
#(
  parameter int unsigned DEPTH = DefDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // req_type, item_value, market_tag, target_id, new_priority
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status, entry_id, entry_value, entry_priority, entry_market, entry_count
  output logic [79:0] m_axis_tdata
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_CHG2 = 3'd2;
  localparam logic [2:0] S_SORT = 3'd3;
  localparam logic [2:0] S_RPT  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] occ_q, occ_d;
  logic [CntW-1:0] pass_q, pass_d;
  logic [15:0]     nid_q, nid_d;
  logic [73:0]     req_q;
  entry_t          hold_q, hold_d;
  logic [1:0]      st_q, st_d;
  entry_t          res_q, res_d;
  logic [6:0]      cnt_q, cnt_d;
  cell_cmd_t       cmd;

  logic [2:0]        r_type;
  logic [30:0]       r_val;
  logic [15:0]       r_mk;
  logic [15:0]       r_tid;
  logic signed [7:0] r_pri;

  entry_t ent   [DEPTH];
  entry_t pick  [DEPTH];
  entry_t pick_or [DEPTH];
  logic   gt    [DEPTH];
  logic   found [DEPTH];
  logic   in_use [DEPTH];

  assign r_type = req_q[2:0];
  assign r_val  = req_q[33:3];
  assign r_mk   = req_q[49:34];
  assign r_tid  = req_q[65:50];
  assign r_pri  = req_q[73:66];

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign in_use[i] = CntW'(i) < occ_q;
    kpq_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .in_use_i     (in_use[i]),
      .dn_in_use_i  ((i + 1 < DEPTH) ? in_use[(i + 1) % DEPTH] : 1'b0),
      .sort_upper_i ((i % 2) == int'(pass_q[0])),
      .up_i         ((i > 0) ? ent[(i + DEPTH - 1) % DEPTH] : ent[i]),
      .dn_i         ((i + 1 < DEPTH) ? ent[(i + 1) % DEPTH] : ent[i]),
      .gt_prev_i    ((i > 0) ? gt[(i + DEPTH - 1) % DEPTH] : 1'b0),
      .found_prev_i ((i > 0) ? found[(i + DEPTH - 1) % DEPTH] : 1'b0),
      .entry_o      (ent[i]),
      .gt_o         (gt[i]),
      .found_o      (found[i]),
      .pick_o       (pick[i])
    );
    if (i == 0) begin : g_first
      assign pick_or[i] = pick[i];
    end else begin : g_rest
      assign pick_or[i] = pick_or[i-1] | pick[i];
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {cnt_q, res_q.market, res_q.prio, res_q.value, res_q.id, st_q};

  // request sequencer
  always_comb begin
    state_d    = state_q;
    occ_d      = occ_q;
    pass_d     = pass_q;
    nid_d      = nid_q;
    hold_d     = hold_q;
    st_d       = st_q;
    res_d      = res_q;
    cnt_d      = cnt_q;
    cmd.op     = CELL_HOLD;
    cmd.bcast  = '0;
    cmd.tid    = r_tid;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_RPT;
        st_d    = ST_OK;
        case (r_type)
          REQ_PUSH: begin
            if (occ_q == CntW'(DEPTH)) begin
              st_d = ST_FULL;
            end else begin
              cmd.op    = CELL_INSERT;
              cmd.bcast = '{id: nid_q, value: r_val, prio: 8'sd0, market: r_mk};
              res_d     = cmd.bcast;
              occ_d     = occ_q + 1'b1;
              cnt_d     = 7'(occ_d);
              nid_d     = nid_q + 1'b1;
              state_d   = S_OUT;
            end
          end
          REQ_POP: begin
            if (occ_q == '0) begin
              st_d = ST_EMPTY;
            end else begin
              cmd.op  = CELL_SHIFT;
              res_d   = ent[0];
              occ_d   = occ_q - 1'b1;
              cnt_d   = 7'(occ_d);
              state_d = S_OUT;
            end
          end
          REQ_CHANGE: begin
            if (!found[DEPTH-1]) begin
              st_d = ST_NOTFOUND;
            end else begin
              cmd.op      = CELL_REMOVE;
              hold_d      = pick_or[DEPTH-1];
              hold_d.prio = r_pri;
              occ_d       = occ_q - 1'b1;
              state_d     = S_CHG2;
            end
          end
          REQ_DELETE: begin
            if (!found[DEPTH-1]) begin
              st_d = ST_NOTFOUND;
            end else begin
              cmd.op = CELL_REMOVE;
              occ_d  = occ_q - 1'b1;
            end
          end
          REQ_PROMOTE: begin
            if (occ_q == '0) begin
              st_d = ST_EMPTY;
            end else begin
              cmd.op       = CELL_PROMOTE;
              cmd.bcast    = '0;
              cmd.bcast.market = r_mk;
              cmd.bcast.prio   = (ent[0].prio == 8'sd127) ? 8'sd127
                                                          : ent[0].prio + 8'sd1;
              pass_d  = '0;
              state_d = S_SORT;
            end
          end
          default: st_d = ST_OK;
        endcase
      end
      S_CHG2: begin
        cmd.op    = CELL_INSERT;
        cmd.bcast = hold_q;
        occ_d     = occ_q + 1'b1;
        state_d   = S_RPT;
      end
      S_SORT: begin
        cmd.op = CELL_SORT;
        pass_d = pass_q + 1'b1;
        if (pass_q == CntW'(DEPTH - 1)) begin
          state_d = S_RPT;
        end
      end
      S_RPT: begin
        res_d   = (occ_q == '0) ? '0 : ent[0];
        cnt_d   = 7'(occ_q);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      occ_q   <= '0;
      nid_q   <= IdStart;
      pass_q  <= '0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      nid_q   <= nid_d;
      pass_q  <= pass_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_q <= s_axis_tdata[73:0];
    end
    hold_q <= hold_d;
    st_q   <= st_d;
    res_q  <= res_d;
    cnt_q  <= cnt_d;
  end

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CntW'(DEPTH))
    else $error("occupancy above depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && r_type == REQ_PUSH && occ_q != CntW'(DEPTH))
    |=> (occ_q == $past(occ_q) + 1'b1 && nid_q == $past(nid_q) + 1'b1))
    else $error("push did not grow the queue");

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input and output open together");

  a_sort_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SORT && pass_q == CntW'(DEPTH - 1)) |=> state_q == S_RPT)
    else $error("sort did not end after all passes");
`endif

endmodule

@@ verif/tb_keyed_priority_queue.sv @@
module tb_keyed_priority_queue;
  import kpq_pkg::*;

  localparam int unsigned QDepth = DefDepth;
  localparam int unsigned CycleLimit = 400000;

  // directed row kinds
  localparam int unsigned CHK_MODEL = 0;
  localparam int unsigned CHK_FIXED = 1;

  typedef struct packed {
    logic [1:0]        status;
    logic [15:0]       id;
    logic [30:0]       value;
    logic signed [7:0] prio;
    logic [15:0]       market;
    logic [6:0]        count;
  } answer_t;

  typedef struct {
    logic [2:0]        req;
    logic [30:0]       value;
    logic [15:0]       market;
    logic [15:0]       tid;
    logic signed [7:0] prio;
    int unsigned       chk;
    answer_t           fixed;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // req_type, item_value, market_tag, target_id, new_priority
  logic [79:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // status, entry_id, entry_value, entry_priority, entry_market, entry_count
  logic [79:0] m_axis_tdata;

  keyed_priority_queue #(.DEPTH(QDepth)) uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #4 clk_i = ~clk_i;

  // shadow of the sorted queue
  entry_t      shadow_q[$];
  logic [15:0] shadow_next_id;
  answer_t     answer_q[$];
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;

  function automatic bit ranks_above(entry_t a, entry_t b);
    if (a.prio != b.prio) return a.prio > b.prio;
    return a.value > b.value;
  endfunction

  // place below every entry with greater or equal key
  function automatic int place_entry(entry_t e);
    int pos;
    pos = 0;
    while (pos < shadow_q.size() && !ranks_above(e, shadow_q[pos])) pos++;
    shadow_q.insert(pos, e);
    return pos;
  endfunction

  function automatic answer_t top_answer(logic [1:0] st);
    answer_t a;
    a = '0;
    a.status = st;
    if (shadow_q.size() != 0) begin
      a.id = shadow_q[0].id;
      a.value = shadow_q[0].value;
      a.prio = shadow_q[0].prio;
      a.market = shadow_q[0].market;
    end
    a.count = 7'(shadow_q.size());
    return a;
  endfunction

  function automatic answer_t entry_answer(entry_t e);
    answer_t a;
    a.status = ST_OK;
    a.id = e.id;
    a.value = e.value;
    a.prio = e.prio;
    a.market = e.market;
    a.count = 7'(shadow_q.size());
    return a;
  endfunction

  function automatic answer_t queue_request(logic [2:0] req, logic [30:0] val,
                                            logic [15:0] mk, logic [15:0] tid,
                                            logic signed [7:0] np);
    entry_t            e;
    entry_t            sorted[$];
    int                pos;
    logic signed [7:0] lift;
    pos = -1;
    if (req == REQ_CHANGE || req == REQ_DELETE) begin
      for (int i = 0; i < shadow_q.size(); i++) begin
        if (pos < 0 && shadow_q[i].id == tid) pos = i;
      end
    end
    case (req)
      REQ_PUSH: begin
        if (shadow_q.size() >= QDepth) return top_answer(ST_FULL);
        e.id = shadow_next_id;
        e.value = val;
        e.prio = 8'sd0;
        e.market = mk;
        shadow_next_id = shadow_next_id + 16'd1;
        void'(place_entry(e));
        return entry_answer(e);
      end
      REQ_POP: begin
        if (shadow_q.size() == 0) return top_answer(ST_EMPTY);
        e = shadow_q.pop_front();
        return entry_answer(e);
      end
      REQ_CHANGE: begin
        if (pos < 0) return top_answer(ST_NOTFOUND);
        e = shadow_q[pos];
        shadow_q.delete(pos);
        e.prio = np;
        void'(place_entry(e));
        return top_answer(ST_OK);
      end
      REQ_DELETE: begin
        if (pos < 0) return top_answer(ST_NOTFOUND);
        shadow_q.delete(pos);
        return top_answer(ST_OK);
      end
      REQ_PROMOTE: begin
        if (shadow_q.size() == 0) return top_answer(ST_EMPTY);
        lift = (shadow_q[0].prio == 8'sd127) ? 8'sd127 : shadow_q[0].prio + 8'sd1;
        // stable re-sort: rebuild in order, each placed below equal keys
        foreach (shadow_q[i]) begin
          e = shadow_q[i];
          if (e.market == mk) e.prio = lift;
          pos = 0;
          while (pos < sorted.size() && !ranks_above(e, sorted[pos])) pos++;
          sorted.insert(pos, e);
        end
        shadow_q = sorted;
        return top_answer(ST_OK);
      end
      default: return top_answer(ST_OK);
    endcase
  endfunction

  // valid stays high from one word to the next when no idle cycles are drawn
  task automatic send_word(logic [2:0] req, logic [30:0] val, logic [15:0] mk,
                           logic [15:0] tid, logic signed [7:0] np);
    int unsigned gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata <= {6'd0, np, tid, mk, val, req};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic issue(logic [2:0] req, logic [30:0] val, logic [15:0] mk,
                       logic [15:0] tid, logic signed [7:0] np);
    answer_t a;
    a = queue_request(req, val, mk, tid, np);
    answer_q.push_back(a);
    send_word(req, val, mk, tid, np);
  endtask

  // result checker with random stall
  initial begin
    answer_t got, want;
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      got.status = m_axis_tdata[1:0];
      got.id     = m_axis_tdata[17:2];
      got.value  = m_axis_tdata[48:18];
      got.prio   = m_axis_tdata[56:49];
      got.market = m_axis_tdata[72:57];
      got.count  = m_axis_tdata[79:73];
      if (answer_q.size() == 0) begin
        $error("unexpected word %h", m_axis_tdata);
        fail_cnt++;
      end else begin
        want = answer_q.pop_front();
        if (got.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, got.status); fail_cnt++;
        end
        if (got.id !== want.id) begin
          $error("entry_id exp %0d got %0d", want.id, got.id); fail_cnt++;
        end
        if (got.value !== want.value) begin
          $error("entry_value exp %0d got %0d", want.value, got.value); fail_cnt++;
        end
        if (got.prio !== want.prio) begin
          $error("entry_priority exp %0d got %0d", want.prio, got.prio); fail_cnt++;
        end
        if (got.market !== want.market) begin
          $error("entry_market exp %0d got %0d", want.market, got.market); fail_cnt++;
        end
        if (got.count !== want.count) begin
          $error("entry_count exp %0d got %0d", want.count, got.count); fail_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // stimulus
  initial begin
    row_t        rows[$];
    row_t        r;
    answer_t     z;
    answer_t     a;
    int unsigned kind;
    logic [15:0] tid;
    logic [15:0] mk;
    z = '0;
    shadow_next_id = IdStart;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: empty-queue errors, extremes, every request code
    z.status = ST_EMPTY;
    rows.push_back('{REQ_POP, 0, 0, 0, 0, CHK_FIXED, z});
    rows.push_back('{REQ_PROMOTE, 0, 16'hffff, 0, 0, CHK_FIXED, z});
    z.status = ST_NOTFOUND;
    rows.push_back('{REQ_CHANGE, 0, 0, 16'd1000, 8'sd5, CHK_FIXED, z});
    rows.push_back('{REQ_DELETE, 0, 0, 16'hffff, 0, CHK_FIXED, z});
    z.status = ST_OK;
    rows.push_back('{3'd7, 0, 0, 0, 0, CHK_FIXED, z});
    z = '{ST_OK, 16'd1000, 31'h7fffffff, 8'sd0, 16'hffff, 7'd1};
    rows.push_back('{REQ_PUSH, 31'h7fffffff, 16'hffff, 0, 0, CHK_FIXED, z});
    rows.push_back('{REQ_PUSH, 31'd0, 16'd0, 0, 0, CHK_MODEL, z});
    rows.push_back('{REQ_PUSH, 31'd5, 16'hffff, 0, 0, CHK_MODEL, z});
    rows.push_back('{REQ_PUSH, 31'd5, 16'h1234, 0, 0, CHK_MODEL, z});
    rows.push_back('{REQ_CHANGE, 0, 0, 16'd1001, 8'sd127, CHK_MODEL, z});
    rows.push_back('{REQ_PROMOTE, 0, 16'hffff, 0, 0, CHK_MODEL, z});
    rows.push_back('{REQ_CHANGE, 0, 0, 16'd1000, 8'sh80, CHK_MODEL, z});
    rows.push_back('{REQ_PROMOTE, 0, 16'h1234, 0, 0, CHK_MODEL, z});
    rows.push_back('{3'd5, 0, 0, 0, 0, CHK_MODEL, z});
    rows.push_back('{3'd6, 0, 0, 0, 0, CHK_MODEL, z});
    rows.push_back('{REQ_DELETE, 0, 0, 16'd1002, 0, CHK_MODEL, z});
    rows.push_back('{REQ_DELETE, 0, 0, 16'd999, 0, CHK_MODEL, z});
    rows.push_back('{REQ_POP, 0, 0, 0, 0, CHK_MODEL, z});
    rows.push_back('{REQ_POP, 0, 0, 0, 0, CHK_MODEL, z});
    rows.push_back('{REQ_POP, 0, 0, 0, 0, CHK_MODEL, z});
    rows.push_back('{REQ_POP, 0, 0, 0, 0, CHK_MODEL, z});
    foreach (rows[i]) begin
      r = rows[i];
      a = queue_request(r.req, r.value, r.market, r.tid, r.prio);
      if (r.chk == CHK_FIXED) a = r.fixed;
      answer_q.push_back(a);
      send_word(r.req, r.value, r.market, r.tid, r.prio);
    end

    // fill to full, then push on full
    while (shadow_q.size() < QDepth)
      issue(REQ_PUSH, 31'($urandom), 16'($urandom_range(0, 3)), 0, 0);
    issue(REQ_PUSH, 31'($urandom), 16'h0, 0, 0);
    issue(REQ_PROMOTE, 0, 16'd2, 0, 0);

    // random: mostly live ids and a few shared market tags
    for (int n = 0; n < 720; n++) begin
      kind = $urandom_range(0, 99);
      mk = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      tid = 16'($urandom);
      if (shadow_q.size() != 0 && $urandom_range(0, 4) != 0)
        tid = shadow_q[$urandom_range(0, shadow_q.size() - 1)].id;
      if (shadow_q.size() < 8 && kind < 60) kind = 0;
      if (kind < 30) issue(REQ_PUSH, 31'($urandom), mk, 0, 0);
      else if (kind < 45) issue(REQ_POP, 0, mk, tid, 0);
      else if (kind < 65) issue(REQ_CHANGE, 31'($urandom), mk, tid, 8'($urandom));
      else if (kind < 80) issue(REQ_DELETE, 31'($urandom), mk, tid, 8'($urandom));
      else if (kind < 95) issue(REQ_PROMOTE, 31'($urandom), mk, tid, 8'($urandom));
      else issue(3'($urandom_range(5, 7)), 31'($urandom), mk, tid, 8'($urandom));
    end

    // drain, then alternate push and pop on a nearly empty queue
    while (shadow_q.size() != 0) issue(REQ_POP, 0, 0, 0, 0);
    for (int n = 0; n < 40; n++) begin
      issue(REQ_PUSH, 31'($urandom), 16'($urandom_range(0, 1)), 0, 0);
      issue(REQ_POP, 0, 0, 0, 0);
    end
    s_axis_tvalid <= 1'b0;

    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (QDepth + 20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ keyed_priority_queue.f @@
rtl/kpq_pkg.sv
rtl/kpq_cell.sv
rtl/keyed_priority_queue.sv
verif/tb_keyed_priority_queue.sv
